### rtl/core/kabf_pkg.sv
// Package for the angle/bias Kalman filter: widths, types, codes and saturation.
package kabf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 17;
    localparam int OP_W      = DATA_W + 1;                     // multiplier operand
    localparam int PROD_W    = 2 * OP_W;                       // exact product / wide sums
    localparam int DTP_W     = DATA_W + CFG_W - FRAC_BITS + 1; // dt * P11 after rounding
    localparam int DIVD_W    = DATA_W + FRAC_BITS;             // scaled dividend
    localparam int DCNT_W    = $clog2(DIVD_W + 1);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic        [CFG_W-1:0]  cfg_t;
    typedef logic signed [OP_W-1:0]   op_t;
    typedef logic signed [PROD_W-1:0] sum_t;
    typedef logic signed [DTP_W-1:0]  dtp_t;

    // configuration register indexes
    localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

    localparam cfg_t ANGLE_NOISE_RST   = cfg_t'(66);
    localparam cfg_t BIAS_NOISE_RST    = cfg_t'(197);
    localparam cfg_t MEASURE_NOISE_RST = cfg_t'(1966);

    typedef enum logic [4:0] {
        S_IDLE,
        S_RATE,
        S_M_ANG,
        S_W_ANG,
        S_M_DTP,
        S_W_DTP,
        S_PRED,
        S_M_P00,
        S_W_P00,
        S_M_P11,
        S_W_P11,
        S_GAIN,
        S_DLD0,
        S_DIV0,
        S_DFN0,
        S_DLD1,
        S_DIV1,
        S_DFN1,
        S_M_ANG2,
        S_W_ANG2,
        S_M_BIAS,
        S_W_BIAS,
        S_M_P10C,
        S_W_P10C,
        S_M_P11C,
        S_W_P11C,
        S_M_P00C,
        S_W_P00C,
        S_M_P01C,
        S_W_P01C,
        S_DONE
    } state_t;

    localparam sum_t SAT_HI = sum_t'(32'sh7FFF_FFFF);
    localparam sum_t SAT_LO = sum_t'(32'sh8000_0000);

    function automatic data_t sat32(input sum_t v);
        data_t r;
        if (v > SAT_HI)
            r = data_t'(32'sh7FFF_FFFF);
        else if (v < SAT_LO)
            r = data_t'(32'sh8000_0000);
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

### rtl/core/kalman_angle_bias_filter.sv
// Two-state angle/bias Kalman filter on one shared multiplier and a serial divider.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: measured_angle,
//   measured_rate and step_time, all fixed point with 16 fraction bits.
//   Output channel (out_valid/out_ready) returns filtered_angle and
//   bias_estimate, one result per request, in order.
//   Config port: cfg_wr_en/cfg_index/cfg_data writes angle_noise (0),
//   bias_noise (1) or measure_noise (2); index 3 is ignored. Write only
//   while idle.
// Schedule:
//   out_valid rises in the same cycle as in_ready, so the filter takes a new
//   request only when it is through with the last one. The two gain
//   divides dominate: a restoring divider resolves one quotient bit per cycle
//   over the 48-bit scaled dividend, twice. Ten 33x33 products share one
//   registered multiplier.
// Reset: state, covariance and bias clear to zero, noise registers take
//   their defaults, both channels go idle.
// Stall: the result sits in an output register; if it has not been taken
//   when the next one is ready, the sequencer waits before loading it.
module kalman_angle_bias_filter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  kabf_pkg::data_t       measured_angle,
    input  kabf_pkg::data_t       measured_rate,
    input  kabf_pkg::cfg_t        step_time,
    output logic                  out_valid,
    input  logic                  out_ready,
    output kabf_pkg::data_t       filtered_angle,
    output kabf_pkg::data_t       bias_estimate,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  kabf_pkg::cfg_t        cfg_data
);

    kabf_pkg::state_t state_reg, state_next;

    // configuration
    kabf_pkg::cfg_t angle_noise_reg, bias_noise_reg, measure_noise_reg;

    // filter state
    kabf_pkg::data_t ang_reg, bias_reg;
    kabf_pkg::data_t p00_reg, p01_reg, p10_reg, p11_reg;

    // per-request working registers
    kabf_pkg::data_t ma_reg, mr_reg;
    kabf_pkg::cfg_t  dt_reg;
    kabf_pkg::data_t rate_reg, inner_reg, s_reg, y_reg, k0_reg, k1_reg;
    kabf_pkg::dtp_t  dtp_reg;

    // shared multiplier
    kabf_pkg::op_t   mul_a, mul_b;
    kabf_pkg::sum_t  prod_reg, rnd, mq;

    // serial divider
    logic [kabf_pkg::DATA_W-1:0] den_mag_reg, rem_reg;
    logic [kabf_pkg::DIVD_W-1:0] quo_reg;
    logic [kabf_pkg::DCNT_W-1:0] cnt_reg;
    logic                        neg_reg, dzero_reg;
    kabf_pkg::data_t             div_num;
    logic [kabf_pkg::DATA_W-1:0] num_mag, s_mag;
    logic [kabf_pkg::DATA_W:0]   trial, diff;
    logic                        trial_ge;
    kabf_pkg::sum_t              q_ext, q_signed;
    kabf_pkg::data_t             k_final;

    // output stage
    logic            out_valid_reg;
    kabf_pkg::data_t out_angle_reg, out_bias_reg;
    logic            out_load;

    assign out_valid      = out_valid_reg;
    assign filtered_angle = out_angle_reg;
    assign bias_estimate  = out_bias_reg;

    // --- next state ---
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kabf_pkg::S_IDLE:   if (in_valid) state_next = kabf_pkg::S_RATE;
            kabf_pkg::S_RATE:   state_next = kabf_pkg::S_M_ANG;
            kabf_pkg::S_M_ANG:  state_next = kabf_pkg::S_W_ANG;
            kabf_pkg::S_W_ANG:  state_next = kabf_pkg::S_M_DTP;
            kabf_pkg::S_M_DTP:  state_next = kabf_pkg::S_W_DTP;
            kabf_pkg::S_W_DTP:  state_next = kabf_pkg::S_PRED;
            kabf_pkg::S_PRED:   state_next = kabf_pkg::S_M_P00;
            kabf_pkg::S_M_P00:  state_next = kabf_pkg::S_W_P00;
            kabf_pkg::S_W_P00:  state_next = kabf_pkg::S_M_P11;
            kabf_pkg::S_M_P11:  state_next = kabf_pkg::S_W_P11;
            kabf_pkg::S_W_P11:  state_next = kabf_pkg::S_GAIN;
            kabf_pkg::S_GAIN:   state_next = kabf_pkg::S_DLD0;
            kabf_pkg::S_DLD0:   state_next = kabf_pkg::S_DIV0;
            kabf_pkg::S_DIV0:
                if (cnt_reg == kabf_pkg::DCNT_W'(kabf_pkg::DIVD_W - 1))
                    state_next = kabf_pkg::S_DFN0;
            kabf_pkg::S_DFN0:   state_next = kabf_pkg::S_DLD1;
            kabf_pkg::S_DLD1:   state_next = kabf_pkg::S_DIV1;
            kabf_pkg::S_DIV1:
                if (cnt_reg == kabf_pkg::DCNT_W'(kabf_pkg::DIVD_W - 1))
                    state_next = kabf_pkg::S_DFN1;
            kabf_pkg::S_DFN1:   state_next = kabf_pkg::S_M_ANG2;
            kabf_pkg::S_M_ANG2: state_next = kabf_pkg::S_W_ANG2;
            kabf_pkg::S_W_ANG2: state_next = kabf_pkg::S_M_BIAS;
            kabf_pkg::S_M_BIAS: state_next = kabf_pkg::S_W_BIAS;
            kabf_pkg::S_W_BIAS: state_next = kabf_pkg::S_M_P10C;
            kabf_pkg::S_M_P10C: state_next = kabf_pkg::S_W_P10C;
            kabf_pkg::S_W_P10C: state_next = kabf_pkg::S_M_P11C;
            kabf_pkg::S_M_P11C: state_next = kabf_pkg::S_W_P11C;
            kabf_pkg::S_W_P11C: state_next = kabf_pkg::S_M_P00C;
            kabf_pkg::S_M_P00C: state_next = kabf_pkg::S_W_P00C;
            kabf_pkg::S_W_P00C: state_next = kabf_pkg::S_M_P01C;
            kabf_pkg::S_M_P01C: state_next = kabf_pkg::S_W_P01C;
            kabf_pkg::S_W_P01C: state_next = kabf_pkg::S_DONE;
            kabf_pkg::S_DONE:   if (out_load) state_next = kabf_pkg::S_IDLE;
            default:            state_next = kabf_pkg::S_IDLE;
        endcase
    end

    // --- control outputs: handshake, multiplier operand and divider numerator select ---
    always_comb
    begin
        in_ready = (state_reg == kabf_pkg::S_IDLE);
        out_load = (state_reg == kabf_pkg::S_DONE) && (!out_valid_reg || out_ready);
        mul_a    = kabf_pkg::op_t'({1'b0, dt_reg});
        mul_b    = kabf_pkg::op_t'(rate_reg);
        div_num  = p00_reg;
        case (state_reg)
            kabf_pkg::S_M_ANG:  mul_b = kabf_pkg::op_t'(rate_reg);
            kabf_pkg::S_M_DTP:  mul_b = kabf_pkg::op_t'(p11_reg);
            kabf_pkg::S_M_P00:  mul_b = kabf_pkg::op_t'(inner_reg);
            kabf_pkg::S_M_P11:
            begin
                mul_a = kabf_pkg::op_t'({1'b0, bias_noise_reg});
                mul_b = kabf_pkg::op_t'({1'b0, dt_reg});
            end
            kabf_pkg::S_DLD1:   div_num = p10_reg;
            kabf_pkg::S_M_ANG2:
            begin
                mul_a = kabf_pkg::op_t'(k0_reg);
                mul_b = kabf_pkg::op_t'(y_reg);
            end
            kabf_pkg::S_M_BIAS:
            begin
                mul_a = kabf_pkg::op_t'(k1_reg);
                mul_b = kabf_pkg::op_t'(y_reg);
            end
            // P10 and P11 first, so the old P00 and P01 still stand
            kabf_pkg::S_M_P10C:
            begin
                mul_a = kabf_pkg::op_t'(k1_reg);
                mul_b = kabf_pkg::op_t'(p00_reg);
            end
            kabf_pkg::S_M_P11C:
            begin
                mul_a = kabf_pkg::op_t'(k1_reg);
                mul_b = kabf_pkg::op_t'(p01_reg);
            end
            kabf_pkg::S_M_P00C:
            begin
                mul_a = kabf_pkg::op_t'(k0_reg);
                mul_b = kabf_pkg::op_t'(p00_reg);
            end
            kabf_pkg::S_M_P01C:
            begin
                mul_a = kabf_pkg::op_t'(k0_reg);
                mul_b = kabf_pkg::op_t'(p01_reg);
            end
            default:
            begin
                mul_a = kabf_pkg::op_t'({1'b0, dt_reg});
                mul_b = kabf_pkg::op_t'(rate_reg);
            end
        endcase
    end

    // round half up, then floor shift
    assign rnd = prod_reg + (kabf_pkg::sum_t'(1) <<< (kabf_pkg::FRAC_BITS - 1));
    assign mq  = rnd >>> kabf_pkg::FRAC_BITS;

    // divider datapath: one quotient bit per cycle on magnitudes
    assign num_mag  = div_num[kabf_pkg::DATA_W-1] ? (~div_num + 1'b1) : div_num;
    assign s_mag    = s_reg[kabf_pkg::DATA_W-1] ? (~s_reg + 1'b1) : s_reg;
    assign trial    = {rem_reg, quo_reg[kabf_pkg::DIVD_W-1]};
    assign diff     = trial - {1'b0, den_mag_reg};
    assign trial_ge = (trial >= {1'b0, den_mag_reg});
    assign q_ext    = kabf_pkg::sum_t'({1'b0, quo_reg});
    assign q_signed = neg_reg ? -q_ext : q_ext;
    assign k_final  = dzero_reg ? '0 : kabf_pkg::sat32(q_signed);

    // --- control registers and filter state ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= kabf_pkg::S_IDLE;
            out_valid_reg     <= 1'b0;
            angle_noise_reg   <= kabf_pkg::ANGLE_NOISE_RST;
            bias_noise_reg    <= kabf_pkg::BIAS_NOISE_RST;
            measure_noise_reg <= kabf_pkg::MEASURE_NOISE_RST;
            ang_reg           <= '0;
            bias_reg          <= '0;
            p00_reg           <= '0;
            p01_reg           <= '0;
            p10_reg           <= '0;
            p11_reg           <= '0;
            cnt_reg           <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    kabf_pkg::REG_ANGLE_NOISE:   angle_noise_reg   <= cfg_data;
                    kabf_pkg::REG_BIAS_NOISE:    bias_noise_reg    <= cfg_data;
                    kabf_pkg::REG_MEASURE_NOISE: measure_noise_reg <= cfg_data;
                    default:                     ;
                endcase
            end

            case (state_reg)
                kabf_pkg::S_W_ANG:
                    ang_reg <= kabf_pkg::sat32(kabf_pkg::sum_t'(ang_reg) + mq);
                kabf_pkg::S_PRED:
                begin
                    p01_reg <= kabf_pkg::sat32(kabf_pkg::sum_t'(p01_reg)
                                               - kabf_pkg::sum_t'(dtp_reg));
                    p10_reg <= kabf_pkg::sat32(kabf_pkg::sum_t'(p10_reg)
                                               - kabf_pkg::sum_t'(dtp_reg));
                end
                kabf_pkg::S_W_P00:
                    p00_reg <= kabf_pkg::sat32(kabf_pkg::sum_t'(p00_reg) + mq);
                kabf_pkg::S_W_P11:
                    p11_reg <= kabf_pkg::sat32(kabf_pkg::sum_t'(p11_reg) + mq);
                kabf_pkg::S_DLD0, kabf_pkg::S_DLD1:
                    cnt_reg <= '0;
                kabf_pkg::S_DIV0, kabf_pkg::S_DIV1:
                    cnt_reg <= cnt_reg + 1'b1;
                kabf_pkg::S_W_ANG2:
                    ang_reg <= kabf_pkg::sat32(kabf_pkg::sum_t'(ang_reg) + mq);
                kabf_pkg::S_W_BIAS:
                    bias_reg <= kabf_pkg::sat32(kabf_pkg::sum_t'(bias_reg) + mq);
                kabf_pkg::S_W_P10C:
                    p10_reg <= kabf_pkg::sat32(kabf_pkg::sum_t'(p10_reg) - mq);
                kabf_pkg::S_W_P11C:
                    p11_reg <= kabf_pkg::sat32(kabf_pkg::sum_t'(p11_reg) - mq);
                kabf_pkg::S_W_P00C:
                    p00_reg <= kabf_pkg::sat32(kabf_pkg::sum_t'(p00_reg) - mq);
                kabf_pkg::S_W_P01C:
                    p01_reg <= kabf_pkg::sat32(kabf_pkg::sum_t'(p01_reg) - mq);
                default:
                    ;
            endcase
        end
    end

    // --- payload and working registers (no reset) ---
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (out_load)
        begin
            out_angle_reg <= ang_reg;
            out_bias_reg  <= bias_reg;
        end

        case (state_reg)
            kabf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    ma_reg <= measured_angle;
                    mr_reg <= measured_rate;
                    dt_reg <= step_time;
                end
            end
            kabf_pkg::S_RATE:
                rate_reg <= kabf_pkg::sat32(kabf_pkg::sum_t'(mr_reg)
                                            - kabf_pkg::sum_t'(bias_reg));
            kabf_pkg::S_W_DTP:
                dtp_reg <= mq[kabf_pkg::DTP_W-1:0];
            kabf_pkg::S_PRED:
                inner_reg <= kabf_pkg::sat32(kabf_pkg::sum_t'(dtp_reg)
                                             - kabf_pkg::sum_t'(p01_reg)
                                             - kabf_pkg::sum_t'(p10_reg)
                                             + kabf_pkg::sum_t'({1'b0, angle_noise_reg}));
            kabf_pkg::S_GAIN:
            begin
                s_reg <= kabf_pkg::sat32(kabf_pkg::sum_t'(p00_reg)
                                         + kabf_pkg::sum_t'({1'b0, measure_noise_reg}));
                y_reg <= kabf_pkg::sat32(kabf_pkg::sum_t'(ma_reg)
                                         - kabf_pkg::sum_t'(ang_reg));
            end
            kabf_pkg::S_DLD0, kabf_pkg::S_DLD1:
            begin
                den_mag_reg <= s_mag;
                rem_reg     <= '0;
                quo_reg     <= {num_mag, {kabf_pkg::FRAC_BITS{1'b0}}};
                neg_reg     <= div_num[kabf_pkg::DATA_W-1] ^ s_reg[kabf_pkg::DATA_W-1];
                dzero_reg   <= (s_reg == '0);
            end
            kabf_pkg::S_DIV0, kabf_pkg::S_DIV1:
            begin
                rem_reg <= trial_ge ? diff[kabf_pkg::DATA_W-1:0]
                                    : trial[kabf_pkg::DATA_W-1:0];
                quo_reg <= {quo_reg[kabf_pkg::DIVD_W-2:0], trial_ge};
            end
            kabf_pkg::S_DFN0:
                k0_reg <= k_final;
            kabf_pkg::S_DFN1:
                k1_reg <= k_final;
            default:
                ;
        endcase
    end

endmodule
